@@ rtl/height_to_normal_map_unit_assert.svh @@
// Assertion macros for the height-to-normal-map unit.
// Used by modules that include this header; expects clk and rst in scope.
`ifndef HEIGHT_TO_NORMAL_MAP_UNIT_ASSERT_SVH
`define HEIGHT_TO_NORMAL_MAP_UNIT_ASSERT_SVH

// Same-cycle implication, held off during reset
`define HTN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset
`define HTN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/htn_pkg.sv @@
// Shared types and constants for the height-to-normal-map unit.
// No dependencies; imported by the controller, datapath and top level.
package htn_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int WW         = 12;
  localparam int HW         = 13;
  localparam int SW         = 13;
  localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
  localparam int DCNT_W     = XW + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // luma weights
  localparam int LUMA_R = 77;
  localparam int LUMA_G = 150;
  localparam int LUMA_B = 29;

  // arithmetic widths
  localparam int A_W      = 22;
  localparam int SQ_W     = 42;
  localparam int Q_W      = 44;
  localparam int R_W      = 22;
  localparam int RECIP_W  = 26;
  localparam int P_W      = 49;
  localparam int SQRT_STEPS = 22;
  localparam int DIV_STEPS  = 26;
  localparam int ITER_W   = 5;

  localparam logic signed [A_W-1:0] KSCALE = 22'sd65280;
  localparam logic [Q_W-1:0] KSCALE_SQ = 44'd4261478400;
  localparam logic [Q_W-1:0] SQRT_TOP_BIT = 44'd1 << 42;
  localparam logic [R_W-1:0] DIV_INIT = 22'd16384;
  localparam logic signed [P_W-1:0] UNIT40 = 49'sd1 << 40;

  localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_STORE, S_RD0, S_RD1, S_RD2, S_SQ, S_SUM,
    S_SQRT, S_DIV, S_CMUL, S_CBYTE, S_RES
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       rd_sel;
    logic       cap_own;
    logic       cap_side;
    logic       wr_above;
    logic       wr_center;
    logic       square;
    logic       sum;
    logic       sqrt_step;
    logic       div_step;
    logic       cmul;
    logic       cbyte;
    logic [1:0] comp;
    logic       load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_valid;
    logic item_emit;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/htn_ctrl.sv @@
// Sequencer for the height-to-normal-map unit.
// Depends on htn_pkg and the assertion header.
`include "height_to_normal_map_unit_assert.svh"

module htn_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  htn_pkg::dp_status_t status,
  output htn_pkg::ctrl_cmd_t  cmd
);
  import htn_pkg::*;

  state_t state, state_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic [1:0] comp, comp_next;

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter  <= '0;
      comp  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
      comp  <= comp_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    iter_next  = iter;
    comp_next  = comp;
    cmd        = '0;
    cmd.comp   = comp;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (!status.item_valid) state_next = S_IDLE;
          else if (status.item_emit) state_next = S_RD0;
          else state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.wr_center = 1'b1;
        state_next = S_IDLE;
      end
      S_RD0: begin
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.cap_own = 1'b1;
        cmd.rd_sel  = 1'b1;
        state_next  = S_RD2;
      end
      S_RD2: begin
        cmd.cap_side  = 1'b1;
        cmd.wr_above  = 1'b1;
        cmd.wr_center = 1'b1;
        state_next    = S_SQ;
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        iter_next  = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (iter == ITER_W'(SQRT_STEPS - 1)) begin
          iter_next  = '0;
          state_next = S_DIV;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (iter == ITER_W'(DIV_STEPS - 1)) begin
          iter_next  = '0;
          comp_next  = '0;
          state_next = S_CMUL;
        end else begin
          iter_next = iter + 1'b1;
        end
      end
      S_CMUL: begin
        cmd.cmul   = 1'b1;
        state_next = S_CBYTE;
      end
      S_CBYTE: begin
        cmd.cbyte = 1'b1;
        if (comp == 2'd2) begin
          state_next = S_RES;
        end else begin
          comp_next  = comp + 1'b1;
          state_next = S_CMUL;
        end
      end
      S_RES: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `HTN_ASSERT_NOW(a_sqrt_bound, state == S_SQRT, iter <= ITER_W'(SQRT_STEPS - 1), "sqrt overrun")
  `HTN_ASSERT_NOW(a_div_bound, state == S_DIV, iter <= ITER_W'(DIV_STEPS - 1), "divide overrun")
  `HTN_ASSERT_NEXT(a_res_hold, state == S_RES && !status.out_free, state == S_RES, "result lost")
  `HTN_ASSERT_NOW(a_comp_bound, state == S_CMUL || state == S_CBYTE, comp <= 2'd2, "bad component")

endmodule

@@ rtl/htn_datapath.sv @@
// Datapath: config registers, counters, line stores, gradient, sqrt, reciprocal, bytes.
// Depends on htn_pkg; driven by htn_ctrl commands.
module htn_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [htn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [htn_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [31:0]                        s_tdata,
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [31:0]                        m_tdata,
  output logic                               m_tlast,
  input  htn_pkg::ctrl_cmd_t                 cmd,
  output htn_pkg::dp_status_t                status
);
  import htn_pkg::*;

  logic [SW-1:0] strength;
  logic [WW-1:0] width_reg;
  logic [HW-1:0] height_reg;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  logic [XW-1:0]     col;
  logic [ROW_W-1:0]  row;
  logic [DCNT_W-1:0] dcnt;

  logic [XW-1:0] x_r;
  logic          drain_r, top_r, last_r;
  logic [7:0]    lum_r, alpha_in_r;
  logic [7:0]    own_r, up_r, alpha_out_r;

  logic [7:0] center_mem [MAX_WIDTH];
  logic [7:0] above_mem  [MAX_WIDTH];
  logic [7:0] alpha_mem  [MAX_WIDTH];
  logic [7:0] c_rd, a_rd, al_rd;
  logic [XW-1:0] c_addr, a_addr;

  logic [15:0] luma_sum;
  logic [7:0]  lum_in;
  logic        in_drain;
  logic [XW-1:0] x_in;

  logic [7:0] left, right, down, up;
  logic signed [8:0]  dx, dy;
  logic signed [22:0] ax_full, ay_full;
  logic signed [A_W-1:0] ax_r, ay_r;
  logic signed [43:0] axsq_full, aysq_full;
  logic [SQ_W-1:0] axsq_r, aysq_r;

  logic [Q_W-1:0]  sq_v, sq_bit;
  logic [Q_W:0]    sq_res, sq_trial;
  logic [R_W-1:0]  div_rem;
  logic [R_W:0]    div_rem2, div_r;
  logic [RECIP_W-1:0] quot;

  logic signed [A_W-1:0] a_sel;
  logic signed [P_W-1:0] prod, p_r, u_s;
  logic [41:0] u;
  logic [49:0] t;
  logic [7:0]  byte_val;
  logic [7:0]  nx, ny, nz;

  // Effective frame size
  always_comb begin
    if (width_reg == '0) w_eff = WW'(1);
    else if (width_reg > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = width_reg;
    if (height_reg == '0) h_eff = HW'(1);
    else if (height_reg > HW'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else h_eff = height_reg;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      strength   <= SW'(768);
      width_reg  <= WW'(2048);
      height_reg <= HW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STRENGTH: strength   <= cfg_data[SW-1:0];
        CFG_WIDTH:    width_reg  <= cfg_data[WW-1:0];
        CFG_HEIGHT:   height_reg <= cfg_data[HW-1:0];
        default: ;
      endcase
    end
  end

  // Decode the incoming item
  assign in_drain = s_tuser;
  assign luma_sum = 16'(s_tdata[7:0] * LUMA_R) + 16'(s_tdata[15:8] * LUMA_G)
                  + 16'(s_tdata[23:16] * LUMA_B);
  assign lum_in = luma_sum[15:8];
  assign x_in = in_drain ? (dcnt[XW] ? XW'(MAX_WIDTH - 1) : dcnt[XW-1:0]) : col;

  assign status.item_valid = in_drain ? (row >= ROW_W'(h_eff)) : (row < ROW_W'(h_eff));
  assign status.item_emit  = in_drain | (row != '0);
  assign status.out_free   = !m_tvalid || m_tready;

  // Counters, advanced on each accepted valid item
  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      dcnt <= '0;
    end else if (cmd.accept && status.item_valid) begin
      if (in_drain) begin
        if ((dcnt + 1'b1) >= DCNT_W'(w_eff)) begin
          col  <= '0;
          row  <= '0;
          dcnt <= '0;
        end else begin
          dcnt <= dcnt + 1'b1;
        end
      end else if (({1'b0, col} + 1'b1) >= DCNT_W'(w_eff)) begin
        col <= '0;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r        <= x_in;
      drain_r    <= in_drain;
      lum_r      <= lum_in;
      alpha_in_r <= s_tdata[31:24];
      top_r      <= (row == ROW_W'(1));
      last_r     <= in_drain && ((dcnt + 1'b1) >= DCNT_W'(w_eff));
    end
  end

  // Line stores: read own column first, then the neighbors
  assign c_addr = cmd.rd_sel ? x_r + 1'b1 : x_r;
  assign a_addr = cmd.rd_sel ? x_r - 1'b1 : x_r;

  always_ff @(posedge clk) begin
    c_rd  <= center_mem[c_addr];
    a_rd  <= above_mem[a_addr];
    al_rd <= alpha_mem[x_r];
    if (cmd.wr_above) above_mem[x_r] <= own_r;
    if (cmd.wr_center && !drain_r) begin
      center_mem[x_r] <= lum_r;
      alpha_mem[x_r]  <= alpha_in_r;
    end
  end

  // Neighbors with clamp-to-edge
  assign left  = (x_r == '0) ? own_r : a_rd;
  assign right = (({1'b0, x_r} + 1'b1) >= DCNT_W'(w_eff)) ? own_r : c_rd;
  assign up    = top_r ? own_r : up_r;
  assign down  = drain_r ? own_r : lum_r;
  assign dx = $signed({1'b0, left}) - $signed({1'b0, right});
  assign dy = $signed({1'b0, up}) - $signed({1'b0, down});
  assign ax_full = 23'(dx) * 23'($signed({1'b0, strength}));
  assign ay_full = 23'(dy) * 23'($signed({1'b0, strength}));
  assign axsq_full = 44'(ax_r) * 44'(ax_r);
  assign aysq_full = 44'(ay_r) * 44'(ay_r);

  // Gradient and squares
  always_ff @(posedge clk) begin
    if (cmd.cap_own) begin
      own_r       <= c_rd;
      up_r        <= a_rd;
      alpha_out_r <= al_rd;
    end
    if (cmd.cap_side) begin
      ax_r <= ax_full[A_W-1:0];
      ay_r <= ay_full[A_W-1:0];
    end
    if (cmd.square) begin
      axsq_r <= axsq_full[SQ_W-1:0];
      aysq_r <= aysq_full[SQ_W-1:0];
    end
  end

  // Integer square root, one result bit per step; reciprocal, one quotient bit per step
  assign sq_trial = sq_res + {1'b0, sq_bit};
  assign div_r    = {1'b0, sq_res[R_W-1:0]};
  assign div_rem2 = {div_rem, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sq_v    <= {2'b0, axsq_r} + {2'b0, aysq_r} + KSCALE_SQ;
      sq_res  <= '0;
      sq_bit  <= SQRT_TOP_BIT;
      div_rem <= DIV_INIT;
      quot    <= '0;
    end else if (cmd.sqrt_step) begin
      if ({1'b0, sq_v} >= sq_trial) begin
        sq_v   <= sq_v - sq_trial[Q_W-1:0];
        sq_res <= (sq_res >> 1) + {1'b0, sq_bit};
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end else if (cmd.div_step) begin
      if (div_rem2 >= div_r) begin
        div_rem <= R_W'(div_rem2 - div_r);
        quot    <= {quot[RECIP_W-2:0], 1'b1};
      end else begin
        div_rem <= div_rem2[R_W-1:0];
        quot    <= {quot[RECIP_W-2:0], 1'b0};
      end
    end
  end

  // Component scaling and byte mapping
  always_comb begin
    case (cmd.comp)
      2'd0:    a_sel = ax_r;
      2'd1:    a_sel = ay_r;
      default: a_sel = KSCALE;
    endcase
  end
  assign prod = P_W'(a_sel) * P_W'($signed({1'b0, quot}));
  assign u_s  = p_r + UNIT40;
  assign u    = u_s[41:0];
  assign t    = {u, 8'd0} - {8'd0, u};
  assign byte_val = t[49] ? 8'd255 : t[48:41];

  always_ff @(posedge clk) begin
    if (cmd.cmul) p_r <= prod;
    if (cmd.cbyte) begin
      case (cmd.comp)
        2'd0:    nx <= byte_val;
        2'd1:    ny <= byte_val;
        default: nz <= byte_val;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {alpha_out_r, nz, ny, nx};
      m_tlast <= last_r;
    end
  end

endmodule

@@ rtl/height_to_normal_map_unit.sv @@
// Top level of the height-to-normal-map unit.
// Depends on htn_pkg, htn_ctrl and htn_datapath.
//
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tdata: red, green, blue, alpha; tuser: drain
// m_        out  m_tvalid/m_tready  tdata: normal_x, normal_y, normal_z, alpha_out; tlast
// cfg_      in   cfg_we             cfg_index, cfg_data
//
// An item that produces a result is accepted, then passes through the line store reads and
// the gradient, the bit-serial square root, the bit-serial reciprocal and the three
// component bytes before the output is loaded. A first-row pixel is accepted and then
// stored; an ignored item is only accepted. Reset is synchronous and clears counters
// and control; line stores are not cleared. A held result stalls the sequencer only
// at its final step; input is taken again once it moves out.
module height_to_normal_map_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [31:0]                    s_tdata,   // red, green, blue, alpha
  input  logic                           s_tuser,   // drain
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,   // normal_x, normal_y, normal_z, alpha_out
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [htn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [htn_pkg::CFG_DATA_W-1:0] cfg_data
);
  import htn_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  htn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  htn_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
